@@ hdl/sound_cpu_mailbox_irq_macros.svh @@
// Assertion macros used by the mailbox core (scmb_core)
`ifndef SOUND_CPU_MAILBOX_IRQ_MACROS_SVH
`define SOUND_CPU_MAILBOX_IRQ_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define SCMB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mailbox check failed");

// Next-cycle implication
`define SCMB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mailbox check failed");

`endif

@@ hdl/scmb_pkg.sv @@
// Package: payload types and decode constants of the sound CPU mailbox
`timescale 1ns / 1ps
package scmb_pkg;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  coin_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic [7:0] irq_vector;
    logic       rom_bank;
  } out_item_t;

  // transaction kinds
  localparam logic [2:0] FN_MAIN_RD  = 3'd0;
  localparam logic [2:0] FN_MAIN_WR  = 3'd1;
  localparam logic [2:0] FN_SND_RD   = 3'd2;
  localparam logic [2:0] FN_SND_WR   = 3'd3;
  localparam logic [2:0] FN_FM_IRQ   = 3'd4;

  // main side word offsets
  localparam logic [2:0] MW_LATCH0   = 3'd0;
  localparam logic [2:0] MW_LATCH1   = 3'd1;
  localparam logic [2:0] MW_REPLY0   = 3'd2;
  localparam logic [2:0] MW_REPLY1   = 3'd3;
  localparam logic [2:0] MW_KICK     = 3'd4;
  localparam logic [2:0] MW_PENDING  = 3'd5;
  localparam logic [2:0] MW_SEND     = 3'd6;

  // sound side addresses
  localparam logic [15:0] SA_ACK      = 16'h4000;
  localparam logic [15:0] SA_VEC_INIT = 16'h4001;
  localparam logic [15:0] SA_RST18CLR = 16'h4003;
  localparam logic [15:0] SA_BANK     = 16'h4007;
  localparam logic [15:0] SA_LATCH0   = 16'h4010;
  localparam logic [15:0] SA_LATCH1   = 16'h4011;
  localparam logic [15:0] SA_PENDING  = 16'h4012;
  localparam logic [15:0] SA_COIN     = 16'h4013;
  localparam logic [15:0] SA_REPLY0   = 16'h4018;
  localparam logic [15:0] SA_REPLY1   = 16'h4019;

  localparam logic [7:0] VEC_BOTH   = 8'hd7;
  localparam logic [7:0] VEC_RST18  = 8'hdf;
  localparam logic [7:0] VEC_NONE   = 8'hff;
  localparam logic [7:0] MAIN_UNMAP = 8'hff;

endpackage

@@ hdl/scmb_core.sv @@
// Mailbox state, address decode and interrupt vector logic
`timescale 1ns / 1ps
`include "sound_cpu_mailbox_irq_macros.svh"
module scmb_core
  import scmb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      kick_also_rst10,
  input  logic      go,
  input  in_item_t  item,
  output out_item_t result
);

  logic [7:0] to_sound_latch [2];
  logic [7:0] to_main_latch  [2];
  logic       to_sound_pending, to_main_pending;
  logic       rst10_active, rst18_active;
  logic       line_state, bank_bit;
  logic [7:0] vector_reg;

  logic [7:0] to_sound_latch_next [2];
  logic [7:0] to_main_latch_next  [2];
  logic       to_sound_pending_next, to_main_pending_next;
  logic       rst10_active_next, rst18_active_next;
  logic       line_state_next, bank_bit_next;
  logic [7:0] vector_reg_next;
  logic [7:0] rd;
  logic [2:0] word;
  logic       ack_wr;

  assign word   = item.address[3:1];
  assign ack_wr = go && item.func == FN_SND_WR && item.address == SA_ACK;

  always_comb begin
    to_sound_latch_next   = to_sound_latch;
    to_main_latch_next    = to_main_latch;
    to_sound_pending_next = to_sound_pending;
    to_main_pending_next  = to_main_pending;
    rst10_active_next     = rst10_active;
    rst18_active_next     = rst18_active;
    bank_bit_next         = bank_bit;
    line_state_next       = line_state;
    vector_reg_next       = vector_reg;
    rd                    = '0;

    unique case (item.func)
      FN_MAIN_RD: begin
        unique case (word)
          MW_REPLY0:  rd = to_main_latch[0];
          MW_REPLY1:  rd = to_main_latch[1];
          MW_PENDING: rd = {7'd0, to_sound_pending};
          default:    rd = MAIN_UNMAP;
        endcase
      end
      FN_MAIN_WR: begin
        unique case (word)
          MW_LATCH0: to_sound_latch_next[0] = item.data;
          MW_LATCH1: to_sound_latch_next[1] = item.data;
          MW_KICK: begin
            if (kick_also_rst10) rst10_active_next = 1'b1;
            rst18_active_next = 1'b1;
          end
          MW_SEND: begin
            to_main_pending_next  = 1'b0;
            to_sound_pending_next = 1'b1;
          end
          default: ;
        endcase
      end
      FN_SND_RD: begin
        unique case (item.address)
          SA_LATCH0:  rd = to_sound_latch[0];
          SA_LATCH1:  rd = to_sound_latch[1];
          SA_PENDING: rd = {7'd0, to_main_pending};
          SA_COIN:    rd = item.coin_bits;
          default:    rd = '0;
        endcase
      end
      FN_SND_WR: begin
        unique case (item.address)
          SA_ACK: begin
            to_sound_pending_next = 1'b0;
            to_main_pending_next  = 1'b1;
          end
          SA_VEC_INIT: begin
            rst10_active_next = 1'b0;
            rst18_active_next = 1'b0;
          end
          SA_RST18CLR: rst18_active_next = 1'b0;
          SA_BANK:     bank_bit_next = item.data[0];
          SA_REPLY0:   to_main_latch_next[0] = item.data;
          SA_REPLY1:   to_main_latch_next[1] = item.data;
          default: ;
        endcase
      end
      FN_FM_IRQ: rst10_active_next = item.data[0];
      default: ;
    endcase

    // RST10 alone leaves line and vector untouched; a kick's two updates
    // collapse to one since the second overrides the first
    if (!rst10_active_next && !rst18_active_next) begin
      line_state_next = 1'b0;
    end else if (rst18_active_next) begin
      line_state_next = 1'b1;
      vector_reg_next = rst10_active_next ? VEC_BOTH : VEC_RST18;
    end
  end

  assign result = '{read_data:  rd,
                    irq_line:   line_state_next,
                    irq_vector: vector_reg_next,
                    rom_bank:   bank_bit_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      to_sound_latch   <= '{default: '0};
      to_main_latch    <= '{default: '0};
      to_sound_pending <= 1'b0;
      to_main_pending  <= 1'b0;
      rst10_active     <= 1'b0;
      rst18_active     <= 1'b0;
      line_state       <= 1'b0;
      vector_reg       <= VEC_NONE;
      bank_bit         <= 1'b0;
    end else if (go) begin
      to_sound_latch   <= to_sound_latch_next;
      to_main_latch    <= to_main_latch_next;
      to_sound_pending <= to_sound_pending_next;
      to_main_pending  <= to_main_pending_next;
      rst10_active     <= rst10_active_next;
      rst18_active     <= rst18_active_next;
      line_state       <= line_state_next;
      vector_reg       <= vector_reg_next;
      bank_bit         <= bank_bit_next;
    end
  end

  `SCMB_ASSERT_NOW(a_line_vec, line_state, vector_reg == VEC_BOTH || vector_reg == VEC_RST18)
  `SCMB_ASSERT_NOW(a_rst18_line, rst18_active, line_state)
  `SCMB_ASSERT_NOW(a_idle_low, !rst10_active && !rst18_active, !line_state)
  `SCMB_ASSERT_NEXT(a_ack, ack_wr, to_main_pending && !to_sound_pending)

endmodule

@@ hdl/sound_cpu_mailbox_irq.sv @@
// Top level: sound CPU mailbox with input and result registers
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------
//  in       | in_valid / in_stall   | in_item  (in_item_t)
//  out      | out_valid / out_stall | out_item (out_item_t)
//  cfg      | cfg_valid / cfg_ready | cfg_data (kick_also_rst10)
//
// One transaction per cycle while out_stall does not hold the output register.
// The input register feeds the decode, whose result lands in the output register.
// Reset (rst, synchronous) clears latches, flags, bank bit; vector goes to 0xff.
// A stall on out holds the result and backs up to in_stall after one more item.
`timescale 1ns / 1ps
module sound_cpu_mailbox_irq
  import scmb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic      kick_also_rst10;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;
  logic      go;
  out_item_t result;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign go        = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      kick_also_rst10 <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      kick_also_rst10 <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_item <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_item <= result;
  end

  scmb_core u_core (
    .clk             (clk),
    .rst             (rst),
    .kick_also_rst10 (kick_also_rst10),
    .go              (go),
    .item            (s1_item),
    .result          (result)
  );

endmodule
